[design/rv32s_pkg.sv]
// ----------------------------------------------------------------------------
// rv32s_pkg
// Shared constants, opcodes and interface structs of the RV32E subset core.
// ----------------------------------------------------------------------------
package rv32s_pkg;

	localparam int XLEN      = 32;
	localparam int RAM_BYTES = 65536;
	localparam int NUM_REGS  = 16;
	localparam int REG_W     = $clog2(NUM_REGS);
	localparam int BANKS     = 4;
	localparam int ROWS      = RAM_BYTES / BANKS;
	localparam int ROW_W     = $clog2(ROWS);

	localparam logic [6:0] OP_ADDI  = 7'b0010011;
	localparam logic [6:0] OP_JALR  = 7'b1100111;
	localparam logic [6:0] OP_ADD   = 7'b0110011;
	localparam logic [6:0] OP_LUI   = 7'b0110111;
	localparam logic [6:0] OP_LOAD  = 7'b0000011;
	localparam logic [6:0] OP_STORE = 7'b0100011;

	localparam logic [2:0] F3_WORD  = 3'b010;
	localparam logic [2:0] F3_BYTEU = 3'b100;
	localparam logic [2:0] F3_BYTE  = 3'b000;

	localparam logic [3:0] MASK_WORD = 4'hf;
	localparam logic [3:0] MASK_BYTE = 4'h1;

	typedef struct packed {
		logic             en;
		logic [REG_W-1:0] idx;
		logic [XLEN-1:0]  data;
	} rf_wr_t;

	typedef struct packed {
		logic            st;
		logic [XLEN-1:0] addr;
		logic [XLEN-1:0] data;
		logic [3:0]      mask;
	} dmem_req_t;

	typedef struct packed {
		logic [XLEN-1:0] word;
		logic [7:0]      lbyte;
	} dmem_rsp_t;

endpackage

[design/rv32e_subset_single_cycle_core.sv]
// ----------------------------------------------------------------------------
// rv32e_subset_single_cycle_core
// Executes one RV32E subset instruction per transaction and reports its
// effects.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/instruction) takes the word fetched at
//   the current PC; the core tracks the PC itself and reports it in instr_pc.
//   Output channel (out_valid/out_stall/...) gives one result transaction per
//   instruction, in order.
//   Path: an accepted instruction moves from stage 1 to stage 2 to the output register.
//   Throughput: one instruction per cycle while the output does not stall; an
//   instruction whose rs1 or rs2 field names the destination of the load right
//   ahead of it is held in stage 1 for the synchronous data RAM read (load-use bubble).
//   Register file operands come from a registered-read RAM with forwarding
//   from the two older writebacks.
//   Reset: PC, registers and data RAM are zero. After reset the data RAM is
//   swept one row of four bytes per cycle across all 16384 rows, during which
//   in_stall is high.
//   Receiver stall: the output register holds; the pipeline behind it freezes,
//   and in_stall rises once the first stage is occupied.
// ----------------------------------------------------------------------------
module rv32e_subset_single_cycle_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instruction,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] instr_pc,
	output logic [31:0] next_pc,
	output logic        reg_write,
	output logic [3:0]  reg_index,
	output logic [31:0] reg_value,
	output logic        mem_store,
	output logic [31:0] mem_addr,
	output logic [31:0] mem_data,
	output logic [3:0]  byte_mask,
	output logic        unimplemented
);

	localparam int RW = rv32s_pkg::REG_W;

	// control
	logic adv, hazard, s1_go, s1_free, accept, dm_busy;

	// stage 1
	logic        s1_valid;
	logic [31:0] instr_s1;
	logic [31:0] pc_s1;
	logic [31:0] pc_q;

	// stage 2
	logic          s2_valid;
	logic [31:0]   pc_s2, npc_s2, alu_s2, addr_s2, sdata_s2;
	logic          wen_s2, is_ld_s2, st_s2, unimp_s2;
	logic [RW-1:0] rd_s2;
	logic [2:0]    f3_s2;
	logic [3:0]    mask_s2;

	// output stage
	logic          out_valid_s3;
	logic [31:0]   pc_s3, npc_s3, val_s3, addr_s3, sdata_s3;
	logic          wen_s3, st_s3, unimp_s3;
	logic [RW-1:0] rd_s3;
	logic [3:0]    mask_s3;

	rv32s_pkg::rf_wr_t    wr, wb_q;
	rv32s_pkg::dmem_req_t dreq;
	rv32s_pkg::dmem_rsp_t drsp;

	logic [RW-1:0] ra1, ra2, rd_c, rs1_c, rs2_c;
	logic [31:0]   rf1, rf2, rs1v, rs2v;
	logic [6:0]    op;
	logic [2:0]    f3;
	logic [31:0]   imm_i, imm_s, opb, sum, pc4, npc_c, alu_c, addr_c, sdata_c;
	logic          wr_c, wen_c, ld_c, st_c, unimp_c;
	logic [3:0]    mask_c;
	logic [31:0]   ld_val, val_s2;

	// handshake
	assign adv     = !out_valid_s3 || !out_stall;
	assign hazard  = s1_valid && s2_valid && is_ld_s2 && wen_s2 &&
	                 (rd_s2 == rs1_c || rd_s2 == rs2_c);
	assign s1_go   = s1_valid && adv && !hazard;
	assign s1_free = !s1_valid || s1_go;
	assign in_stall = dm_busy || !s1_free;
	assign accept  = in_valid && !in_stall;

	// operand read: new word on accept, else re-read for the held instruction
	assign ra1 = accept ? instruction[15 +: RW] : instr_s1[15 +: RW];
	assign ra2 = accept ? instruction[20 +: RW] : instr_s1[20 +: RW];

	rv32s_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.ra1    (ra1),
		.ra2    (ra2),
		.wr     (wr),
		.rd1    (rf1),
		.rd2    (rf2)
	);

	// decode / execute
	always_comb begin
		op    = instr_s1[6:0];
		f3    = instr_s1[14:12];
		rd_c  = instr_s1[7 +: RW];
		rs1_c = instr_s1[15 +: RW];
		rs2_c = instr_s1[20 +: RW];
		imm_i = {{20{instr_s1[31]}}, instr_s1[31:20]};
		imm_s = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};

		if (s2_valid && wen_s2 && !is_ld_s2 && rd_s2 == rs1_c) begin
			rs1v = alu_s2;
		end else if (wb_q.en && wb_q.idx == rs1_c) begin
			rs1v = wb_q.data;
		end else begin
			rs1v = rf1;
		end
		if (s2_valid && wen_s2 && !is_ld_s2 && rd_s2 == rs2_c) begin
			rs2v = alu_s2;
		end else if (wb_q.en && wb_q.idx == rs2_c) begin
			rs2v = wb_q.data;
		end else begin
			rs2v = rf2;
		end

		if (op == rv32s_pkg::OP_ADD) begin
			opb = rs2v;
		end else if (op == rv32s_pkg::OP_STORE) begin
			opb = imm_s;
		end else begin
			opb = imm_i;
		end
		sum   = rs1v + opb;
		pc4   = pc_s1 + 32'd4;
		npc_c = pc4;

		wr_c    = 1'b0;
		ld_c    = 1'b0;
		st_c    = 1'b0;
		unimp_c = 1'b0;
		alu_c   = '0;
		addr_c  = '0;
		sdata_c = '0;
		mask_c  = '0;

		unique case (op)
			rv32s_pkg::OP_ADDI, rv32s_pkg::OP_ADD: begin
				wr_c  = 1'b1;
				alu_c = sum;
			end
			rv32s_pkg::OP_LUI: begin
				wr_c  = 1'b1;
				alu_c = {instr_s1[31:12], 12'd0};
			end
			rv32s_pkg::OP_JALR: begin
				wr_c  = 1'b1;
				alu_c = pc4;
				npc_c = {sum[31:2], 2'b00};
			end
			rv32s_pkg::OP_LOAD: begin
				wr_c   = 1'b1;
				ld_c   = 1'b1;
				addr_c = sum;
			end
			rv32s_pkg::OP_STORE: begin
				st_c    = 1'b1;
				addr_c  = sum;
				sdata_c = rs2v;
				if (f3 == rv32s_pkg::F3_WORD) begin
					mask_c = rv32s_pkg::MASK_WORD;
				end else if (f3 == rv32s_pkg::F3_BYTE) begin
					mask_c = rv32s_pkg::MASK_BYTE;
				end
			end
			default: begin
				unimp_c = 1'b1;
			end
		endcase

		wen_c = wr_c && (rd_c != '0);
		if (!wen_c) begin
			alu_c = '0;
		end
	end

	assign dreq.st   = st_c;
	assign dreq.addr = sum;
	assign dreq.data = rs2v;
	assign dreq.mask = mask_c;

	rv32s_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_go),
		.req    (dreq),
		.busy   (dm_busy),
		.rsp    (drsp)
	);

	// writeback value
	always_comb begin
		if (f3_s2 == rv32s_pkg::F3_WORD) begin
			ld_val = drsp.word;
		end else if (f3_s2 == rv32s_pkg::F3_BYTEU) begin
			ld_val = {24'd0, drsp.lbyte};
		end else begin
			ld_val = '0;
		end
		if (!wen_s2) begin
			val_s2 = '0;
		end else if (is_ld_s2) begin
			val_s2 = ld_val;
		end else begin
			val_s2 = alu_s2;
		end
	end

	assign wr.en   = adv && s2_valid && wen_s2;
	assign wr.idx  = rd_s2;
	assign wr.data = val_s2;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid     <= 1'b0;
			s2_valid     <= 1'b0;
			out_valid_s3 <= 1'b0;
			pc_q         <= '0;
			wb_q         <= '0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_go) begin
				s1_valid <= 1'b0;
			end
			if (s1_go) begin
				pc_q <= npc_c;
			end
			if (adv) begin
				s2_valid     <= s1_go;
				out_valid_s3 <= s2_valid;
				wb_q         <= wr;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instruction;
			pc_s1    <= s1_go ? npc_c : pc_q;
		end
		if (s1_go) begin
			pc_s2    <= pc_s1;
			npc_s2   <= npc_c;
			alu_s2   <= alu_c;
			wen_s2   <= wen_c;
			rd_s2    <= wen_c ? rd_c : '0;
			is_ld_s2 <= ld_c;
			f3_s2    <= f3;
			st_s2    <= st_c;
			addr_s2  <= addr_c;
			sdata_s2 <= sdata_c;
			mask_s2  <= mask_c;
			unimp_s2 <= unimp_c;
		end
		if (adv && s2_valid) begin
			pc_s3    <= pc_s2;
			npc_s3   <= npc_s2;
			wen_s3   <= wen_s2;
			rd_s3    <= rd_s2;
			val_s3   <= val_s2;
			st_s3    <= st_s2;
			addr_s3  <= addr_s2;
			sdata_s3 <= sdata_s2;
			mask_s3  <= mask_s2;
			unimp_s3 <= unimp_s2;
		end
	end

	assign out_valid     = out_valid_s3;
	assign instr_pc      = pc_s3;
	assign next_pc       = npc_s3;
	assign reg_write     = wen_s3;
	assign reg_index     = 4'(rd_s3);
	assign reg_value     = val_s3;
	assign mem_store     = st_s3;
	assign mem_addr      = addr_s3;
	assign mem_data      = sdata_s3;
	assign byte_mask     = mask_s3;
	assign unimplemented = unimp_s3;

endmodule

[design/rv32s_ram.sv]
// ----------------------------------------------------------------------------
// rv32s_ram
// Generic single-write, single-read RAM with registered read (read-old).
// ----------------------------------------------------------------------------
module rv32s_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/rv32s_regfile.sv]
// ----------------------------------------------------------------------------
// rv32s_regfile
// Two-read, one-write register file; per-entry valid bits give zero reset.
// ----------------------------------------------------------------------------
module rv32s_regfile (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [rv32s_pkg::REG_W-1:0]         ra1,
	input  logic [rv32s_pkg::REG_W-1:0]         ra2,
	input  rv32s_pkg::rf_wr_t                   wr,
	output logic [rv32s_pkg::XLEN-1:0]          rd1,
	output logic [rv32s_pkg::XLEN-1:0]          rd2
);

	logic [rv32s_pkg::NUM_REGS-1:0] valid_q;
	logic                           v1_q;
	logic                           v2_q;
	logic [rv32s_pkg::XLEN-1:0]     q1;
	logic [rv32s_pkg::XLEN-1:0]     q2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
		end else begin
			v1_q <= valid_q[ra1];
			v2_q <= valid_q[ra2];
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
		end
	end

	rv32s_ram #(.WIDTH(rv32s_pkg::XLEN), .DEPTH(rv32s_pkg::NUM_REGS)) u_ram1 (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (1'b1),
		.raddr (ra1),
		.rdata (q1)
	);

	rv32s_ram #(.WIDTH(rv32s_pkg::XLEN), .DEPTH(rv32s_pkg::NUM_REGS)) u_ram2 (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (1'b1),
		.raddr (ra2),
		.rdata (q2)
	);

	assign rd1 = v1_q ? q1 : '0;
	assign rd2 = v2_q ? q2 : '0;

endmodule

[design/rv32s_dmem.sv]
// ----------------------------------------------------------------------------
// rv32s_dmem
// Byte data RAM as four byte banks: unaligned little-endian access, bounds
// checks per byte, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module rv32s_dmem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  rv32s_pkg::dmem_req_t  req,
	output logic                  busy,
	output rv32s_pkg::dmem_rsp_t  rsp
);

	localparam int NB = rv32s_pkg::BANKS;

	logic                         clr_busy_q;
	logic [rv32s_pkg::ROW_W-1:0]  clr_row_q;
	logic [1:0]                   off;
	logic [30:0]                  row_base;
	logic [NB-1:0]                inr;
	logic [1:0]                   off_s2;
	logic [NB-1:0]                inr_s2;
	logic [7:0]                   bd [NB];
	logic [rv32s_pkg::XLEN-1:0]   word;

	assign off      = req.addr[1:0];
	assign row_base = {1'b0, req.addr[31:2]};
	assign busy     = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == rv32s_pkg::ROW_W'(rv32s_pkg::ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	for (genvar b = 0; b < NB; b++) begin : g_bank
		logic [1:0]                  k;
		logic                        lt;
		logic [30:0]                 row_full;
		logic [rv32s_pkg::ROW_W-1:0] ra;
		logic                        we;
		logic [rv32s_pkg::ROW_W-1:0] wa;
		logic [7:0]                  wd;

		always_comb begin
			k        = 2'(b) - off;
			lt       = 2'(b) < off;
			row_full = row_base + {30'd0, lt};
			inr[b]   = row_full < 31'(rv32s_pkg::ROWS);
			ra       = row_full[rv32s_pkg::ROW_W-1:0];
			if (clr_busy_q) begin
				we = 1'b1;
				wa = clr_row_q;
				wd = '0;
			end else begin
				we = step && req.st && req.mask[k] && inr[b];
				wa = ra;
				wd = req.data[{k, 3'b000} +: 8];
			end
		end

		rv32s_ram #(.WIDTH(8), .DEPTH(rv32s_pkg::ROWS)) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (wa),
			.wdata (wd),
			.re    (step),
			.raddr (ra),
			.rdata (bd[b])
		);
	end

	always_ff @(posedge clk) begin
		if (step) begin
			off_s2 <= off;
			inr_s2 <= inr;
		end
	end

	always_comb begin
		for (int k = 0; k < NB; k++) begin
			word[8*k +: 8] = bd[off_s2 + 2'(k)];
		end
		rsp.word  = (&inr_s2) ? word : '0;
		rsp.lbyte = inr_s2[off_s2] ? bd[off_s2] : '0;
	end

endmodule

[design/rv32s_checker.sv]
// ----------------------------------------------------------------------------
// rv32s_checker
// Port-level assertions on the result channel of the core, bound to the top.
// ----------------------------------------------------------------------------
module rv32s_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] instr_pc,
	input logic [31:0] next_pc,
	input logic        reg_write,
	input logic [3:0]  reg_index,
	input logic [31:0] reg_value,
	input logic        mem_store,
	input logic [31:0] mem_addr,
	input logic [31:0] mem_data,
	input logic [3:0]  byte_mask,
	input logic        unimplemented
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(instr_pc) && $stable(reg_value))
		else $error("result changed while stalled");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_write |-> reg_index == 4'd0 && reg_value == 32'd0)
		else $error("register fields set without a write");

	a_no_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mem_store |-> byte_mask == 4'd0 && mem_data == 32'd0)
		else $error("store fields set without a store");

	a_unimp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unimplemented |->
			next_pc == instr_pc + 32'd4 && !reg_write && !mem_store && mem_addr == 32'd0)
		else $error("unimplemented opcode had side effects");

endmodule

bind rv32e_subset_single_cycle_core rv32s_checker u_rv32s_checker (.*);
